>>> sv/atrf_pkg.sv
// Package: shared types, constants and helpers of the transmit-request framer.
package atrf_pkg;

  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0]  START_DELIM = 8'h7E;
  localparam logic [7:0]  ESC_MARK    = 8'h7D;
  localparam logic [7:0]  XON_CHAR    = 8'h11;
  localparam logic [7:0]  XOFF_CHAR   = 8'h13;
  localparam logic [7:0]  ESC_XOR     = 8'h20;
  localparam logic [7:0]  TYPE_TX_REQ = 8'h10;
  localparam logic [7:0]  CSUM_BASE   = 8'hFF;
  localparam logic [15:0] LEN_EXTRA   = 16'd14;

  localparam logic [2:0] REG_ADDR64  = 3'd0;
  localparam logic [2:0] REG_ADDR16  = 3'd1;
  localparam logic [2:0] REG_FRAME_ID = 3'd2;
  localparam logic [2:0] REG_RADIUS  = 3'd3;
  localparam logic [2:0] REG_OPTIONS = 3'd4;

  localparam logic [63:0] ADDR64_RST  = 64'h0013_A200_415B_AD6C;
  localparam logic [15:0] ADDR16_RST  = 16'hFFFE;
  localparam logic [7:0]  FRAME_ID_RST = 8'h01;
  localparam logic [7:0]  RADIUS_RST  = 8'h00;
  localparam logic [7:0]  OPTIONS_RST = 8'h00;

  typedef struct packed {
    logic [63:0] addr64;
    logic [15:0] addr16;
    logic [7:0]  frame_id;
    logic [7:0]  radius;
    logic [7:0]  options;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] flen;
  } cmd_t;

  typedef enum logic [4:0] {
    SP_DELIM, SP_LEN_HI, SP_LEN_LO, SP_TYPE, SP_FID,
    SP_A64_7, SP_A64_6, SP_A64_5, SP_A64_4, SP_A64_3, SP_A64_2, SP_A64_1, SP_A64_0,
    SP_A16_HI, SP_A16_LO, SP_RADIUS, SP_OPTIONS, SP_DATA, SP_CSUM
  } step_t;

  typedef enum logic {
    BK_IDLE,
    BK_BUSY
  } bk_state_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == START_DELIM) || (b == ESC_MARK) || (b == XON_CHAR) || (b == XOFF_CHAR);
  endfunction

endpackage

>>> sv/atrf_queue.sv
// Short command queue between the framer front end and the byte sequencer.
module atrf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  atrf_pkg::cmd_t     push_data,
  output logic               push_ready,
  input  logic               pop,
  output atrf_pkg::cmd_t     pop_data,
  output logic               pop_valid
);

  localparam int DEPTH = atrf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  atrf_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/atrf_front.sv
// Front end: accepts payload items, tracks frame position and queues commands.
module atrf_front #(
  parameter int MAX_PAYLOAD = atrf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     payload_byte,
  input  logic [8:0]     payload_length,
  output logic           push,
  output atrf_pkg::cmd_t cmd,
  input  logic           push_ready
);

  localparam int LIM   = (MAX_PAYLOAD < 511) ? MAX_PAYLOAD : 511;
  localparam int CNT_W = $clog2(LIM + 1);

  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [CNT_W-1:0] len_sat;
  logic             last;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  always_comb begin
    if (payload_length == 9'd0) begin
      len_sat = CNT_W'(1);
    end else if (int'(payload_length) > LIM) begin
      len_sat = CNT_W'(LIM);
    end else begin
      len_sat = CNT_W'(payload_length);
    end
  end

  always_comb begin
    if (!in_frame_r) begin
      last           = (len_sat == CNT_W'(1));
      bytes_left_nxt = len_sat - CNT_W'(1);
    end else begin
      last           = (bytes_left_r == CNT_W'(1));
      bytes_left_nxt = bytes_left_r - CNT_W'(1);
    end
    in_frame_nxt = !last;
    cmd.data     = payload_byte;
    cmd.first    = !in_frame_r;
    cmd.last     = last;
    cmd.flen     = 16'(len_sat) + atrf_pkg::LEN_EXTRA;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bytes_left_r <= '0;
    end else if (push) begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

>>> sv/atrf_back.sv
// Back end: steps through header, payload and checksum bytes with escaping.
module atrf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  atrf_pkg::cfg_t cfg,
  input  atrf_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_done
);

  atrf_pkg::bk_state_t state_r, state_nxt;
  atrf_pkg::step_t     step_r, step_nxt;
  logic                esc_r, esc_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic                ov_r, ov_nxt;
  logic [7:0]          ob_r, ob_nxt;
  logic                ol_r, ol_nxt;
  logic                od_r, od_nxt;

  logic [7:0] cur;
  logic       adv, esc_first, item_end;

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_done  = od_r;

  always_comb begin
    case (step_r)
      atrf_pkg::SP_DELIM:   cur = atrf_pkg::START_DELIM;
      atrf_pkg::SP_LEN_HI:  cur = cmd.flen[15:8];
      atrf_pkg::SP_LEN_LO:  cur = cmd.flen[7:0];
      atrf_pkg::SP_TYPE:    cur = atrf_pkg::TYPE_TX_REQ;
      atrf_pkg::SP_FID:     cur = cfg.frame_id;
      atrf_pkg::SP_A64_7:   cur = cfg.addr64[63:56];
      atrf_pkg::SP_A64_6:   cur = cfg.addr64[55:48];
      atrf_pkg::SP_A64_5:   cur = cfg.addr64[47:40];
      atrf_pkg::SP_A64_4:   cur = cfg.addr64[39:32];
      atrf_pkg::SP_A64_3:   cur = cfg.addr64[31:24];
      atrf_pkg::SP_A64_2:   cur = cfg.addr64[23:16];
      atrf_pkg::SP_A64_1:   cur = cfg.addr64[15:8];
      atrf_pkg::SP_A64_0:   cur = cfg.addr64[7:0];
      atrf_pkg::SP_A16_HI:  cur = cfg.addr16[15:8];
      atrf_pkg::SP_A16_LO:  cur = cfg.addr16[7:0];
      atrf_pkg::SP_RADIUS:  cur = cfg.radius;
      atrf_pkg::SP_OPTIONS: cur = cfg.options;
      atrf_pkg::SP_DATA:    cur = cmd.data;
      atrf_pkg::SP_CSUM:    cur = atrf_pkg::CSUM_BASE - sum_r;
      default:              cur = cmd.data;
    endcase
  end

  assign adv       = (state_r == atrf_pkg::BK_BUSY) && (!ov_r || out_ready);
  assign esc_first = !esc_r && (step_r != atrf_pkg::SP_DELIM) && atrf_pkg::needs_esc(cur);
  assign item_end  = !esc_first && ((step_r == atrf_pkg::SP_CSUM) ||
                     ((step_r == atrf_pkg::SP_DATA) && !cmd.last));
  assign cmd_pop   = adv && item_end;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      atrf_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = atrf_pkg::BK_BUSY;
        end
      end
      atrf_pkg::BK_BUSY: begin
        if (adv && item_end) begin
          state_nxt = atrf_pkg::BK_IDLE;
        end
      end
      default: state_nxt = atrf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    esc_nxt  = esc_r;
    sum_nxt  = sum_r;
    ov_nxt   = ov_r && !out_ready;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    od_nxt   = od_r;
    case (state_r)
      atrf_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          esc_nxt = 1'b0;
          if (cmd.first) begin
            step_nxt = atrf_pkg::SP_DELIM;
            sum_nxt  = '0;
          end else begin
            step_nxt = atrf_pkg::SP_DATA;
          end
        end
      end
      atrf_pkg::BK_BUSY: begin
        if (adv) begin
          ov_nxt = 1'b1;
          ob_nxt = esc_r ? (cur ^ atrf_pkg::ESC_XOR) : (esc_first ? atrf_pkg::ESC_MARK : cur);
          ol_nxt = item_end;
          od_nxt = item_end && (step_r == atrf_pkg::SP_CSUM);
          if (esc_first) begin
            esc_nxt = 1'b1;
          end else begin
            esc_nxt = 1'b0;
            if (step_r inside {[atrf_pkg::SP_TYPE:atrf_pkg::SP_DATA]}) begin
              sum_nxt = sum_r + cur;
            end
            if (step_r == atrf_pkg::SP_DATA) begin
              if (cmd.last) begin
                step_nxt = atrf_pkg::SP_CSUM;
              end
            end else if (step_r != atrf_pkg::SP_CSUM) begin
              step_nxt = atrf_pkg::step_t'(step_r + 5'd1);
            end
          end
        end
      end
      default: ov_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atrf_pkg::BK_IDLE;
      step_r  <= atrf_pkg::SP_DELIM;
      esc_r   <= 1'b0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      esc_r   <= esc_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    od_r <= od_nxt;
  end

endmodule

>>> sv/api_tx_request_framer_escaped.sv
// Top level: escaped API transmit-request framer with configuration registers.
// Each input item is one payload byte; the first item of a frame also carries the
// frame's payload length (0 is taken as 1, values above MAX_PAYLOAD saturate).
// The back-end sequencer emits one frame byte per cycle while out_tready allows
// it, but loads each queued item in its idle state, where it starts no byte. The
// first item of a frame adds the 17 header bytes plus their escapes; the last adds
// the checksum byte (2 when escaped). tlast marks the last byte an item causes,
// tuser[0] marks the byte that ends the frame. A two-entry queue lets input items
// be taken while the sequencer or the output stalls.
module api_tx_request_framer_escaped #(
  parameter int MAX_PAYLOAD = atrf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] payload_byte, [16:8] payload_length, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] frame_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  atrf_pkg::cfg_t cfg_r;
  atrf_pkg::cmd_t push_cmd, head_cmd;
  logic           q_push, q_ready, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addr64   <= atrf_pkg::ADDR64_RST;
      cfg_r.addr16   <= atrf_pkg::ADDR16_RST;
      cfg_r.frame_id <= atrf_pkg::FRAME_ID_RST;
      cfg_r.radius   <= atrf_pkg::RADIUS_RST;
      cfg_r.options  <= atrf_pkg::OPTIONS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        atrf_pkg::REG_ADDR64:   cfg_r.addr64   <= cfg_wdata;
        atrf_pkg::REG_ADDR16:   cfg_r.addr16   <= cfg_wdata[15:0];
        atrf_pkg::REG_FRAME_ID: cfg_r.frame_id <= cfg_wdata[7:0];
        atrf_pkg::REG_RADIUS:   cfg_r.radius   <= cfg_wdata[7:0];
        atrf_pkg::REG_OPTIONS:  cfg_r.options  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  atrf_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .payload_byte  (in_tdata[7:0]),
    .payload_length(in_tdata[16:8]),
    .push          (q_push),
    .cmd           (push_cmd),
    .push_ready    (q_ready)
  );

  atrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .pop_valid (q_valid)
  );

  atrf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (head_cmd),
    .cmd_valid(q_valid),
    .cmd_pop  (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_last (out_tlast),
    .out_done (out_tuser[0])
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end byte without tlast");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("sequencer popped an empty queue");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("item queued while queue full");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
